### rtl/rde_pkg.sv
// Shared types and constants of the rectangle draw engine.
`timescale 1ns / 1ps

package rde_pkg;

  localparam int LINE_W          = 13;
  localparam int CFG_DATA_W      = 32;
  localparam int OUT_ADDR_W      = 32;
  localparam int BYTES_PER_PIXEL = 3;
  localparam logic [LINE_W-1:0] LINE_PIXELS_RST = 13'd1280;

  typedef enum logic {
    CFG_FRAME_BASE  = 1'b0,
    CFG_LINE_PIXELS = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    FUNC_START   = 1'b0,
    FUNC_ADVANCE = 1'b1
  } func_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  // Classification of one request as it travels from front to back.
  typedef struct packed {
    logic   is_start;
    logic   outline;
    color_t color;
  } cmd_hdr_t;

endpackage

### rtl/rde_if.sv
// Handshake channels of the rectangle draw engine: requests, pixel writes, configuration.
`timescale 1ns / 1ps

interface rde_req_if #(parameter int COORD_BITS = 12) ();
  logic                  valid;
  logic                  ready;
  rde_pkg::func_e        func;
  logic [COORD_BITS-1:0] x_pos;
  logic [COORD_BITS-1:0] y_pos;
  logic [COORD_BITS:0]   width;
  logic [COORD_BITS:0]   height;
  logic [7:0]            red;
  logic [7:0]            green;
  logic [7:0]            blue;
  logic                  outline;

  modport source (output valid, func, x_pos, y_pos, width, height, red, green, blue, outline,
                  input ready);
  modport sink   (input valid, func, x_pos, y_pos, width, height, red, green, blue, outline,
                  output ready);
endinterface

interface rde_res_if ();
  logic                              valid;
  logic                              ready;
  logic [rde_pkg::OUT_ADDR_W-1:0]    byte_address;
  logic [7:0]                        out_blue;
  logic [7:0]                        out_green;
  logic [7:0]                        out_red;
  logic                              last_pixel;

  modport source (output valid, byte_address, out_blue, out_green, out_red, last_pixel,
                  input ready);
  modport sink   (input valid, byte_address, out_blue, out_green, out_red, last_pixel,
                  output ready);
endinterface

interface rde_cfg_if ();
  logic                              valid;
  logic                              ready;
  rde_pkg::cfg_reg_e                 index;
  logic [rde_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/rde_front.sv
// Front end: configuration registers and the start address pipeline.
`timescale 1ns / 1ps

module rde_front #(
  parameter int COORD_BITS = 12,
  parameter int ADDR_BITS  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rde_req_if.sink                       req_i,
  rde_cfg_if.sink                       cfg_i,
  output logic                          cmd_valid_o,
  input  logic                          cmd_ready_i,
  output rde_pkg::cmd_hdr_t             hdr_o,
  output logic [ADDR_BITS-1:0]          addr_o,
  output logic [COORD_BITS:0]           w_o,
  output logic [COORD_BITS:0]           h_o,
  output logic [rde_pkg::LINE_W+1:0]    row_step_o
);

  localparam int SZ_W   = COORD_BITS + 1;
  localparam int STEP_W = rde_pkg::LINE_W + 2;
  localparam int PROD_W = COORD_BITS + STEP_W;
  localparam int X3_W   = COORD_BITS + 2;
  localparam logic [STEP_W-1:0] STEP_RST =
      STEP_W'(rde_pkg::BYTES_PER_PIXEL * int'(rde_pkg::LINE_PIXELS_RST));

  logic [rde_pkg::CFG_DATA_W-1:0] base_q;
  logic [STEP_W-1:0]              step_q;
  logic [rde_pkg::LINE_W-1:0]     line_wr;

  logic                           s1_v_q;
  rde_pkg::cmd_hdr_t              s1_hdr_q;
  logic [PROD_W-1:0]              s1_prod_q;
  logic [X3_W-1:0]                s1_x3_q;
  logic [SZ_W-1:0]                s1_w_q, s1_h_q;

  logic                           s2_v_q;
  rde_pkg::cmd_hdr_t              s2_hdr_q;
  logic [ADDR_BITS-1:0]           s2_addr_q;
  logic [SZ_W-1:0]                s2_w_q, s2_h_q;

  logic                           s1_adv, s2_adv;

  assign cfg_i.ready = 1'b1;
  assign line_wr     = cfg_i.data[rde_pkg::LINE_W-1:0];

  // Keep the line length as bytes from one scan line to the next
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      step_q <= STEP_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        rde_pkg::CFG_FRAME_BASE:  base_q <= cfg_i.data;
        rde_pkg::CFG_LINE_PIXELS: step_q <= {1'b0, line_wr, 1'b0} + {2'b00, line_wr};
        default:                  base_q <= base_q;
      endcase
    end
  end

  assign row_step_o = step_q;

  assign s2_adv      = !s2_v_q || cmd_ready_i;
  assign s1_adv      = !s1_v_q || s2_adv;
  assign req_i.ready = s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_adv) s1_v_q <= req_i.valid;
      if (s2_adv) s2_v_q <= s1_v_q;
    end
  end

  // Stage one: row offset multiply, column offset in parallel
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s1_hdr_q.is_start    <= (req_i.func == rde_pkg::FUNC_START);
      s1_hdr_q.outline     <= req_i.outline;
      s1_hdr_q.color.red   <= req_i.red;
      s1_hdr_q.color.green <= req_i.green;
      s1_hdr_q.color.blue  <= req_i.blue;
      s1_prod_q <= PROD_W'(req_i.y_pos) * PROD_W'(step_q);
      s1_x3_q   <= {1'b0, req_i.x_pos, 1'b0} + {2'b00, req_i.x_pos};
      s1_w_q    <= req_i.width;
      s1_h_q    <= req_i.height;
    end
  end

  // Stage two: add the frame base, wrap at the address width
  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      s2_hdr_q  <= s1_hdr_q;
      s2_addr_q <= ADDR_BITS'(base_q) + ADDR_BITS'(s1_prod_q) + ADDR_BITS'(s1_x3_q);
      s2_w_q    <= s1_w_q;
      s2_h_q    <= s1_h_q;
    end
  end

  assign cmd_valid_o = s2_v_q;
  assign hdr_o       = s2_hdr_q;
  assign addr_o      = s2_addr_q;
  assign w_o         = s2_w_q;
  assign h_o         = s2_h_q;

endmodule

### rtl/rde_fifo.sv
// Short first-in first-out queue between front and back.
`timescale 1ns / 1ps

module rde_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign wr_ready_o = (cnt_q != CNT_FULL);
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      if (pop)  rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      if (push && !pop)      cnt_q <= cnt_q + CNT_W'(1);
      else if (pop && !push) cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

### rtl/rde_back.sv
// Back end: rectangle walker and registered pixel write output.
`timescale 1ns / 1ps

module rde_back #(
  parameter int COORD_BITS = 12,
  parameter int ADDR_BITS  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  rde_pkg::cmd_hdr_t             hdr_i,
  input  logic [ADDR_BITS-1:0]          addr_i,
  input  logic [COORD_BITS:0]           w_i,
  input  logic [COORD_BITS:0]           h_i,
  input  logic [rde_pkg::LINE_W+1:0]    row_step_i,
  rde_res_if.source                     res_o
);

  localparam int SZ_W = COORD_BITS + 1;

  logic                   busy_q;
  logic [SZ_W-1:0]        row_q, col_q, w_last_q, h_last_q;
  logic [ADDR_BITS-1:0]   pix_q, row_addr_q;
  rde_pkg::color_t        color_q;
  logic                   border_q;

  logic                   out_v_q;
  logic [rde_pkg::OUT_ADDR_W-1:0] out_addr_q;
  rde_pkg::color_t        out_color_q;
  logic                   out_last_q;

  logic                   out_free, take_start, take_pix;
  logic                   last_col, last_row, edge_px;
  logic [ADDR_BITS-1:0]   row_next;
  rde_pkg::color_t        pix_color;

  assign out_free    = !out_v_q || res_o.ready;
  assign take_start  = cmd_valid_i && hdr_i.is_start;
  assign take_pix    = cmd_valid_i && !hdr_i.is_start && busy_q && out_free;
  // Advances while idle are dropped at once
  assign cmd_ready_o = hdr_i.is_start || !busy_q || out_free;

  assign last_col  = (col_q == w_last_q);
  assign last_row  = (row_q == h_last_q);
  assign edge_px   = (row_q == '0) || last_row || (col_q == '0) || last_col;
  assign pix_color = (!border_q || edge_px) ? color_q : '0;
  assign row_next  = row_addr_q + ADDR_BITS'(row_step_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      row_q      <= '0;
      col_q      <= '0;
      w_last_q   <= '0;
      h_last_q   <= '0;
      pix_q      <= '0;
      row_addr_q <= '0;
      color_q    <= '0;
      border_q   <= 1'b0;
    end else if (take_start) begin
      busy_q     <= (w_i != '0) && (h_i != '0);
      row_q      <= '0;
      col_q      <= '0;
      w_last_q   <= w_i - SZ_W'(1);
      h_last_q   <= h_i - SZ_W'(1);
      pix_q      <= addr_i;
      row_addr_q <= addr_i;
      color_q    <= hdr_i.color;
      border_q   <= hdr_i.outline;
    end else if (take_pix) begin
      if (last_col) begin
        col_q <= '0;
        if (last_row) begin
          busy_q <= 1'b0;
          row_q  <= '0;
        end else begin
          row_q      <= row_q + SZ_W'(1);
          row_addr_q <= row_next;
          pix_q      <= row_next;
        end
      end else begin
        col_q <= col_q + SZ_W'(1);
        pix_q <= pix_q + ADDR_BITS'(rde_pkg::BYTES_PER_PIXEL);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (take_pix) begin
      out_v_q <= 1'b1;
    end else if (res_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_pix) begin
      out_addr_q  <= rde_pkg::OUT_ADDR_W'(pix_q);
      out_color_q <= pix_color;
      out_last_q  <= last_col && last_row;
    end
  end

  assign res_o.valid        = out_v_q;
  assign res_o.byte_address = out_addr_q;
  assign res_o.out_blue     = out_color_q.blue;
  assign res_o.out_green    = out_color_q.green;
  assign res_o.out_red      = out_color_q.red;
  assign res_o.last_pixel   = out_last_q;

endmodule

### rtl/rectangle_draw_engine.sv
// Top level of the rectangle draw engine: front, command queue and back.
`timescale 1ns / 1ps

// A start request latches a rectangle and its colour and gives no pixel write;
// each later advance request gives one pixel write in row-major order, until the
// write flagged last_pixel. Requests and pixel writes both move at one per clock
// cycle while the pixel output is not held; the walker's column and row counters
// and its two address adders step one pixel at a time, and the start address (one
// multiply stage, one add stage) is pipelined ahead of it. A request passes both
// front stages and the command queue before the output register; the command queue
// lets the front keep taking requests while the pixel output is held.
module rectangle_draw_engine #(
  parameter int COORD_BITS  = 12,
  parameter int ADDR_BITS   = 32,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rde_req_if.sink    req_i,
  rde_res_if.source  res_o,
  rde_cfg_if.sink    cfg_i
);

  localparam int SZ_W   = COORD_BITS + 1;
  localparam int STEP_W = rde_pkg::LINE_W + 2;
  localparam int CMD_W  = $bits(rde_pkg::cmd_hdr_t) + ADDR_BITS + 2 * SZ_W;

  logic                 f_valid, f_ready;
  rde_pkg::cmd_hdr_t    f_hdr;
  logic [ADDR_BITS-1:0] f_addr;
  logic [SZ_W-1:0]      f_w, f_h;
  logic [STEP_W-1:0]    row_step;

  logic                 q_valid, q_ready;
  logic [CMD_W-1:0]     q_data;
  rde_pkg::cmd_hdr_t    q_hdr;
  logic [ADDR_BITS-1:0] q_addr;
  logic [SZ_W-1:0]      q_w, q_h;

  rde_front #(
    .COORD_BITS (COORD_BITS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_i       (cfg_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .hdr_o       (f_hdr),
    .addr_o      (f_addr),
    .w_o         (f_w),
    .h_o         (f_h),
    .row_step_o  (row_step)
  );

  rde_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  ({f_hdr, f_addr, f_w, f_h}),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_data)
  );

  assign {q_hdr, q_addr, q_w, q_h} = q_data;

  rde_back #(
    .COORD_BITS (COORD_BITS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .hdr_i       (q_hdr),
    .addr_i      (q_addr),
    .w_i         (q_w),
    .h_i         (q_h),
    .row_step_i  (row_step),
    .res_o       (res_o)
  );

endmodule

### rtl/rde_checker.sv
// Port checks of the rectangle draw engine and their binding to the top level.
`timescale 1ns / 1ps

module rde_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [56:0] res_data_i,
  input logic        cfg_ready_i
);

  // Hold a pixel write that is not taken
  a_res_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("pixel write withdrawn while stalled");

  a_res_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_data_i))
    else $error("pixel write changed while stalled");

  // No pixel write can be pending while in reset
  a_rst_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !res_valid_i)
    else $error("pixel write offered during reset");

  // Configuration writes are never back-pressured
  a_cfg_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |-> cfg_ready_i)
    else $error("configuration request stalled");

endmodule

bind rectangle_draw_engine rde_checker u_rde_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_data_i  ({res_o.byte_address, res_o.out_blue, res_o.out_green, res_o.out_red,
                 res_o.last_pixel}),
  .cfg_ready_i (cfg_i.ready)
);

### dv/testbench.sv
// Self-checking testbench of the rectangle draw engine: directed table, then random rectangles.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    rde_pkg::func_e  func;
    logic [11:0]     x_pos;
    logic [11:0]     y_pos;
    logic [12:0]     width;
    logic [12:0]     height;
    rde_pkg::color_t color;
    logic            outline;
  } rect_req_t;

  typedef struct packed {
    logic [rde_pkg::OUT_ADDR_W-1:0] addr;
    rde_pkg::color_t                color;
    logic                           last;
  } pixel_write_t;

  typedef struct packed {
    rect_req_t    rq;
    logic         typed;
    pixel_write_t pix;
  } dir_row_t;

  localparam pixel_write_t NO_PIX = '0;
  localparam rect_req_t ADVANCE_REQ =
      '{rde_pkg::FUNC_ADVANCE, 12'd0, 12'd0, 13'd0, 13'd0, 24'h0, 1'b0};
  localparam int NUM_ROWS = 28;

  // Typed rows: reset configuration (base 0, 1280 pixels per line).
  localparam dir_row_t DIRECTED_ROWS [0:NUM_ROWS-1] = '{
    '{ADVANCE_REQ, 1'b0, NO_PIX},
    '{'{rde_pkg::FUNC_START, 12'd0, 12'd0, 13'd1, 13'd1, 24'h112233, 1'b0}, 1'b0, NO_PIX},
    '{ADVANCE_REQ, 1'b1, '{32'h0000_0000, 24'h112233, 1'b1}},
    '{ADVANCE_REQ, 1'b0, NO_PIX},
    '{'{rde_pkg::FUNC_START, 12'd4095, 12'd4095, 13'd2, 13'd2, 24'hFFFFFF, 1'b1}, 1'b0,
      NO_PIX},
    '{ADVANCE_REQ, 1'b1, '{32'h00F0_20FD, 24'hFFFFFF, 1'b0}},
    '{ADVANCE_REQ, 1'b1, '{32'h00F0_2100, 24'hFFFFFF, 1'b0}},
    '{ADVANCE_REQ, 1'b1, '{32'h00F0_2FFD, 24'hFFFFFF, 1'b0}},
    '{ADVANCE_REQ, 1'b1, '{32'h00F0_3000, 24'hFFFFFF, 1'b1}},
    '{'{rde_pkg::FUNC_START, 12'd1, 12'd0, 13'd3, 13'd3, 24'h804020, 1'b1}, 1'b0, NO_PIX},
    '{ADVANCE_REQ, 1'b0, NO_PIX},
    '{ADVANCE_REQ, 1'b0, NO_PIX},
    '{ADVANCE_REQ, 1'b0, NO_PIX},
    '{ADVANCE_REQ, 1'b0, NO_PIX},
    '{ADVANCE_REQ, 1'b0, NO_PIX},
    '{ADVANCE_REQ, 1'b0, NO_PIX},
    '{ADVANCE_REQ, 1'b0, NO_PIX},
    '{ADVANCE_REQ, 1'b0, NO_PIX},
    '{ADVANCE_REQ, 1'b0, NO_PIX},
    '{'{rde_pkg::FUNC_START, 12'd7, 12'd3, 13'd0, 13'd5, 24'hA5A5A5, 1'b0}, 1'b0, NO_PIX},
    '{ADVANCE_REQ, 1'b0, NO_PIX},
    '{'{rde_pkg::FUNC_START, 12'd7, 12'd3, 13'd5, 13'd0, 24'hA5A5A5, 1'b0}, 1'b0, NO_PIX},
    '{'{rde_pkg::FUNC_START, 12'd0, 12'd0, 13'd8191, 13'd8191, 24'h000000, 1'b0}, 1'b0,
      NO_PIX},
    '{ADVANCE_REQ, 1'b0, NO_PIX},
    '{ADVANCE_REQ, 1'b0, NO_PIX},
    '{'{rde_pkg::FUNC_START, 12'd2, 12'd1, 13'd2, 13'd1, 24'h5A5A5A, 1'b0}, 1'b0, NO_PIX},
    '{ADVANCE_REQ, 1'b0, NO_PIX},
    '{ADVANCE_REQ, 1'b0, NO_PIX}
  };

  logic clk;
  logic rst_n;
  logic gaps_on;
  logic typed_on;
  pixel_write_t typed_pix;
  int mismatches;

  // Engine state as the checker sees it.
  logic [rde_pkg::OUT_ADDR_W-1:0] frame_base = '0;
  logic [rde_pkg::LINE_W-1:0]     line_pixels = rde_pkg::LINE_PIXELS_RST;
  logic                           walking = 1'b0;
  logic [12:0]                    row_idx = '0;
  logic [12:0]                    col_idx = '0;
  logic [rde_pkg::OUT_ADDR_W-1:0] pix_addr = '0;
  logic [rde_pkg::OUT_ADDR_W-1:0] line_addr = '0;
  logic [12:0]                    rect_w = '0;
  logic [12:0]                    rect_h = '0;
  rde_pkg::color_t                fill_color = '0;
  logic                           border_only = 1'b0;
  pixel_write_t                   pending_writes [$];

  rde_req_if #(.COORD_BITS(12)) req_if ();
  rde_res_if                    res_if ();
  rde_cfg_if                    cfg_if ();

  rectangle_draw_engine #(
    .COORD_BITS (12),
    .ADDR_BITS  (32)
  ) i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Apply one accepted request to the walk model: a start latches the rectangle, an advance queues its pixel write.
  task automatic walk_rectangle(input rect_req_t rq, input logic typed, input pixel_write_t tp);
    logic [63:0]  start;
    logic         last_col;
    logic         last_row;
    logic         border;
    pixel_write_t pw;
    if (rq.func == rde_pkg::FUNC_START) begin
      start = 64'(frame_base) +
              64'd3 * (64'(rq.y_pos) * 64'(line_pixels) + 64'(rq.x_pos));
      rect_w      = rq.width;
      rect_h      = rq.height;
      fill_color  = rq.color;
      border_only = rq.outline;
      line_addr   = start[rde_pkg::OUT_ADDR_W-1:0];
      pix_addr    = start[rde_pkg::OUT_ADDR_W-1:0];
      row_idx     = '0;
      col_idx     = '0;
      walking     = (rq.width != 0) && (rq.height != 0);
    end else if (walking) begin
      last_col = (col_idx == rect_w - 13'd1);
      last_row = (row_idx == rect_h - 13'd1);
      border   = (row_idx == 0) || last_row || (col_idx == 0) || last_col;
      pw.addr  = pix_addr;
      pw.color = (!border_only || border) ? fill_color : rde_pkg::color_t'(0);
      pw.last  = last_col && last_row;
      pending_writes.push_back(typed ? tp : pw);
      if (last_col) begin
        col_idx = '0;
        if (last_row) begin
          walking = 1'b0;
          row_idx = '0;
        end else begin
          row_idx   = row_idx + 13'd1;
          line_addr = line_addr + 32'(line_pixels) * 32'd3;
          pix_addr  = line_addr;
        end
      end else begin
        col_idx  = col_idx + 13'd1;
        pix_addr = pix_addr + 32'd3;
      end
    end
  endtask

  // Predict on accepted requests first, then check pixel writes of the same edge.
  always @(posedge clk) begin
    pixel_write_t got;
    pixel_write_t want;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          rde_pkg::CFG_FRAME_BASE:  frame_base = cfg_if.data;
          rde_pkg::CFG_LINE_PIXELS: line_pixels = cfg_if.data[rde_pkg::LINE_W-1:0];
          default: ;
        endcase
      end
      if (req_if.valid && req_if.ready)
        walk_rectangle('{req_if.func, req_if.x_pos, req_if.y_pos, req_if.width, req_if.height,
                         '{req_if.red, req_if.green, req_if.blue}, req_if.outline},
                       typed_on, typed_pix);
      if (res_if.valid && res_if.ready) begin
        got.addr        = res_if.byte_address;
        got.color.red   = res_if.out_red;
        got.color.green = res_if.out_green;
        got.color.blue  = res_if.out_blue;
        got.last        = res_if.last_pixel;
        if (pending_writes.size() == 0) begin
          report_mismatch($sformatf("pixel write at %h with none pending", got.addr));
        end else begin
          want = pending_writes.pop_front();
          if (got.addr !== want.addr)
            report_mismatch($sformatf("byte_address %h, want %h", got.addr, want.addr));
          if (got.color.blue !== want.color.blue)
            report_mismatch($sformatf("out_blue %h, want %h", got.color.blue, want.color.blue));
          if (got.color.green !== want.color.green)
            report_mismatch($sformatf("out_green %h, want %h", got.color.green,
                                      want.color.green));
          if (got.color.red !== want.color.red)
            report_mismatch($sformatf("out_red %h, want %h", got.color.red, want.color.red));
          if (got.last !== want.last)
            report_mismatch($sformatf("last_pixel %b, want %b at %h", got.last, want.last,
                                      want.addr));
        end
      end
    end
  end

  // Pixel write side: drop ready for bursts of random length while gaps_on is set.
  initial begin
    int stall;
    stall = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        res_if.ready = 1'b0;
        stall--;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        res_if.ready = 1'b0;
        stall = $urandom_range(1, 8) - 1;
      end else begin
        res_if.ready = 1'b1;
      end
    end
  end

  function automatic rect_req_t random_request(input rde_pkg::func_e f);
    logic [95:0] noise;
    rect_req_t   rq;
    noise   = {$urandom(), $urandom(), $urandom()};
    rq      = noise[$bits(rect_req_t)-1:0];
    rq.func = f;
    return rq;
  endfunction

  task automatic send_request(input rect_req_t rq, input logic typed, input pixel_write_t tp);
    int gap;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      req_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_if.valid   = 1'b1;
    req_if.func    = rq.func;
    req_if.x_pos   = rq.x_pos;
    req_if.y_pos   = rq.y_pos;
    req_if.width   = rq.width;
    req_if.height  = rq.height;
    req_if.red     = rq.color.red;
    req_if.green   = rq.color.green;
    req_if.blue    = rq.color.blue;
    req_if.outline = rq.outline;
    typed_on       = typed;
    typed_pix      = tp;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  // Drop valid and hold until every pending pixel write has come out.
  task automatic wait_for_writes();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input rde_pkg::cfg_reg_e idx,
                                input logic [rde_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // An empty rectangle leaves the engine idle; let it clear the pipeline too.
  task automatic quiesce_engine();
    rect_req_t rq;
    rq       = random_request(rde_pkg::FUNC_START);
    rq.width = '0;
    send_request(rq, 1'b0, NO_PIX);
    wait_for_writes();
    repeat (16) @(posedge clk);
  endtask

  task automatic draw_random_rects(input int budget);
    int        drawn;
    int        pick;
    int        roll;
    int        area;
    int        steps;
    rect_req_t rq;
    drawn = 0;
    while (drawn < budget) begin
      pick = $urandom_range(0, 99);
      rq   = random_request(rde_pkg::FUNC_START);
      if (pick < 80) begin
        rq.width  = 13'($urandom_range(1, 6));
        rq.height = 13'($urandom_range(1, 6));
      end else if (pick < 87) begin
        rq.width  = 13'($urandom_range(7, 40));
        rq.height = 13'($urandom_range(1, 3));
      end else if (pick < 93) begin
        if ($urandom_range(0, 1) == 1) rq.width = '0;
        else rq.height = '0;
      end else begin
        rq.width  = 13'($urandom_range(1, 8191));
        rq.height = 13'($urandom_range(1, 8191));
      end
      area = int'(rq.width) * int'(rq.height);
      send_request(rq, 1'b0, NO_PIX);
      drawn++;
      if (pick >= 93) begin
        // Large sizes: draw only the first few pixels, then replace.
        steps = $urandom_range(1, 40);
      end else begin
        roll = $urandom_range(0, 19);
        if (roll < 15) steps = area;
        else if (roll < 18) steps = $urandom_range(0, area);
        else steps = area + $urandom_range(1, 3);
      end
      if (steps > area) drawn += area;
      else drawn += steps;
      repeat (steps) send_request(random_request(rde_pkg::FUNC_ADVANCE), 1'b0, NO_PIX);
      if ($urandom_range(0, 39) == 0) wait_for_writes();
    end
  endtask

  initial begin
    logic [rde_pkg::CFG_DATA_W-1:0] base_val;
    logic [rde_pkg::CFG_DATA_W-1:0] line_val;
    mismatches     = 0;
    gaps_on        = 1'b1;
    typed_on       = 1'b0;
    typed_pix      = NO_PIX;
    rst_n          = 1'b0;
    req_if.valid   = 1'b0;
    req_if.func    = rde_pkg::FUNC_START;
    req_if.x_pos   = '0;
    req_if.y_pos   = '0;
    req_if.width   = '0;
    req_if.height  = '0;
    req_if.red     = '0;
    req_if.green   = '0;
    req_if.blue    = '0;
    req_if.outline = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = rde_pkg::CFG_FRAME_BASE;
    cfg_if.data    = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < NUM_ROWS; r++)
      send_request(DIRECTED_ROWS[r].rq, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].pix);

    for (int phase = 0; phase < 5; phase++) begin
      quiesce_engine();
      line_val = $urandom();
      case (phase)
        0: begin
          base_val = $urandom();
          line_val[rde_pkg::LINE_W-1:0] = 13'($urandom_range(1, 4096));
        end
        1: begin
          base_val = 32'hFFFF_FFFF;
          line_val[rde_pkg::LINE_W-1:0] = 13'h1FFF;
        end
        2: begin
          base_val = '0;
          line_val = '0;
        end
        3: begin
          base_val = 32'hFFFF_F000;
          line_val[rde_pkg::LINE_W-1:0] = 13'd4096;
        end
        default: begin
          base_val = $urandom();
          line_val[rde_pkg::LINE_W-1:0] = 13'd1;
          gaps_on = 1'b0;
        end
      endcase
      write_register(rde_pkg::CFG_FRAME_BASE, base_val);
      write_register(rde_pkg::CFG_LINE_PIXELS, line_val);
      draw_random_rects(320);
    end

    wait_for_writes();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
